### sv/rectilinear_to_equirect_remap_top_assert.svh
// assertion macros for the remap block checker
`ifndef RECTILINEAR_TO_EQUIRECT_REMAP_TOP_ASSERT_SVH
`define RECTILINEAR_TO_EQUIRECT_REMAP_TOP_ASSERT_SVH

// implication checked outside reset
`define R2E_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("r2e port check failed");

// property checked at every edge, reset included
`define R2E_ASSERT_ALW(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("r2e port check failed");

`endif

### sv/r2e_pkg.sv
// types, constants and cordic step shared by the remap block
package r2e_pkg;

	localparam int QW = 25;
	localparam int CSTEPS = 24;
	localparam logic [24:0] HALF_PI_Q = 25'd26353589;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [24:0] ATAN_Q24 [CSTEPS] = '{
		25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331, 25'd1047214, 25'd524117,
		25'd262123, 25'd131069, 25'd65536, 25'd32768, 25'd16384, 25'd8192,
		25'd4096, 25'd2048, 25'd1024, 25'd512, 25'd256, 25'd128,
		25'd64, 25'd32, 25'd16, 25'd8, 25'd4, 25'd2
	};

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	localparam logic [1:0] REG_HEIGHT = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_FOCAL = 2'd2;
	localparam logic [1:0] REG_ZOOM = 2'd3;

	// edges from accept to the edge that samples done
	localparam int LATENCY = 1 + (QW + 1) + CSTEPS + 1 + (QW + 1) + 5;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [26:0] z;
	} cord_t;

	typedef struct packed {
		logic cmd;
		logic [7:0] row;
		logic [7:0] col;
		logic [23:0] rgb;
		logic neg_c;
	} ang_tag_t;

	typedef struct packed {
		logic cmd;
		logic [7:0] row;
		logic [7:0] col;
		logic [23:0] rgb;
		logic neg_c;
		logic neg_r;
		logic away;
	} cord_side_t;

	typedef struct packed {
		logic cmd;
		logic [7:0] row;
		logic [7:0] col;
		logic [23:0] rgb;
		logic away;
		logic sc;
	} off_tag_t;

	function automatic cord_t cord_step(cord_t a, int i);
		cord_t r;
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		logic signed [26:0] at;
		xs = a.x >>> i;
		ys = a.y >>> i;
		at = $signed({2'b00, ATAN_Q24[i]});
		if (a.z >= 0) begin
			r.x = a.x - ys;
			r.y = a.y + xs;
			r.z = a.z - at;
		end else begin
			r.x = a.x + ys;
			r.y = a.y - xs;
			r.z = a.z + at;
		end
		return r;
	endfunction

endpackage

### sv/r2e_div.sv
// pipelined restoring divider with bounded quotient and overflow flag
module r2e_div #(
	parameter int NW = 48,
	parameter int DW = 40,
	parameter int QW = 25,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [TW-1:0] out_tag
);
	localparam int HW = NW - QW;
	localparam int CW = (HW > DW) ? HW : DW;

	logic          v_s   [0:QW];
	logic [DW-1:0] r_s   [0:QW];
	logic [DW-1:0] d_s   [0:QW];
	logic [QW-1:0] lo_s  [0:QW];
	logic          ovf_s [0:QW];
	logic [TW-1:0] t_s   [0:QW];

	logic [CW-1:0] hi;
	logic [CW-1:0] dx;

	assign hi = CW'(num[NW-1:QW]);
	assign dx = CW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		r_s[0] <= DW'(hi);
		d_s[0] <= den;
		lo_s[0] <= num[QW-1:0];
		ovf_s[0] <= (hi >= dx);
		t_s[0] <= tag;
	end

	// one quotient bit per stage, quotient shifts into the low bits
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] r2;
		logic [DW:0] diff;
		logic        ge;
		assign r2 = {r_s[k], lo_s[k][QW-1]};
		assign diff = r2 - {1'b0, d_s[k]};
		assign ge = (r2 >= {1'b0, d_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			r_s[k+1] <= ge ? diff[DW-1:0] : r2[DW-1:0];
			d_s[k+1] <= d_s[k];
			lo_s[k+1] <= {lo_s[k][QW-2:0], ge};
			ovf_s[k+1] <= ovf_s[k];
			t_s[k+1] <= t_s[k];
		end
	end

	assign out_valid = v_s[QW];
	assign quo = lo_s[QW];
	assign ovf = ovf_s[QW];
	assign out_tag = t_s[QW];

endmodule

### sv/rectilinear_to_equirect_remap_top.sv
// remap top: angle division, cordic, offset division, frame store and bilinear blend
// done rises for every render item
// throughput: one item per clock, loads and renders alike; busy stays low
// set by a fully pipelined chain: angle and offset dividers, a 24-stage cordic, 4 store banks
// loads write the store in pipeline order, so renders see every earlier load
// reset clears valid bits and output registers and sets config registers to defaults; the store is not cleared
module rectilinear_to_equirect_remap_top #(
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_WIDTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [7:0]  row,
	input  logic [7:0]  col,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        done,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        in_view
);
	import r2e_pkg::*;

	localparam int MHS = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
	localparam int MWS = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int RHA = ($clog2(MHS) > 1) ? $clog2(MHS) - 1 : 1;
	localparam int CHA = ($clog2(MWS) > 1) ? $clog2(MWS) - 1 : 1;
	localparam int AW = RHA + CHA;
	localparam int BDEPTH = 2 ** AW;

	// config
	logic [8:0]  height_q;
	logic [8:0]  width_q;
	logic [23:0] focal_q;
	logic [15:0] zoom_q;
	logic [39:0] fout_q;
	logic [8:0]  h_eff;
	logic [8:0]  w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 9'd256;
			width_q <= 9'd256;
			focal_q <= 24'd65536;
			zoom_q <= 16'd256;
			fout_q <= 40'd16777216;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEIGHT: height_q <= cfg_data[8:0];
					REG_WIDTH: width_q <= cfg_data[8:0];
					REG_FOCAL: focal_q <= cfg_data;
					REG_ZOOM: zoom_q <= cfg_data[15:0];
				endcase
			end
			fout_q <= 40'(focal_q) * 40'(zoom_q);
		end
	end

	assign h_eff = (int'(height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : height_q;
	assign w_eff = (int'(width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : width_q;

	assign busy = 1'b0;

	// entry
	logic        v_s1;
	logic        cmd_s1;
	logic [7:0]  row_s1;
	logic [7:0]  col_s1;
	logic [23:0] rgb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		row_s1 <= row;
		col_s1 <= col;
		rgb_s1 <= {red, green, blue};
	end

	logic signed [10:0] tw_c;
	logic signed [10:0] tw_r;
	logic               neg_c;
	logic               neg_r;
	logic [10:0]        abs_c;
	logic [10:0]        abs_r;
	ang_tag_t           atag_in;

	assign tw_c = $signed({2'b00, col_s1, 1'b0}) - $signed({2'b00, w_eff});
	assign tw_r = $signed({2'b00, row_s1, 1'b0}) - $signed({2'b00, h_eff});
	assign neg_c = tw_c[10];
	assign neg_r = tw_r[10];
	assign abs_c = neg_c ? 11'(-tw_c) : 11'(tw_c);
	assign abs_r = neg_r ? 11'(-tw_r) : 11'(tw_r);
	assign atag_in = '{cmd: cmd_s1, row: row_s1, col: col_s1, rgb: rgb_s1, neg_c: neg_c};

	// angle = |2*pos - size| * 2^39 / fout
	logic          va_c;
	logic          va_r;
	logic [QW-1:0] qa_c;
	logic [QW-1:0] qa_r;
	logic          oa_c;
	logic          oa_r;
	ang_tag_t      atag_out;
	logic          negr_a;

	r2e_div #(.NW(48), .DW(40), .QW(QW), .TW($bits(ang_tag_t))) u_ang_c (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .num({abs_c[8:0], 39'd0}),
		.den(fout_q), .tag(atag_in), .out_valid(va_c), .quo(qa_c), .ovf(oa_c),
		.out_tag(atag_out)
	);

	r2e_div #(.NW(48), .DW(40), .QW(QW), .TW(1)) u_ang_r (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .num({abs_r[8:0], 39'd0}),
		.den(fout_q), .tag(neg_r), .out_valid(va_r), .quo(qa_r), .ovf(oa_r),
		.out_tag(negr_a)
	);

	// cordic, column and row angles side by side
	cord_t      c0_c;
	cord_t      c0_r;
	cord_side_t sd0;
	logic       v0;

	assign c0_c = '{x: CORDIC_GAIN, y: '0, z: $signed({2'b00, qa_c})};
	assign c0_r = '{x: CORDIC_GAIN, y: '0, z: $signed({2'b00, qa_r})};
	assign v0 = va_c & va_r;
	assign sd0 = '{cmd: atag_out.cmd, row: atag_out.row, col: atag_out.col,
		rgb: atag_out.rgb, neg_c: atag_out.neg_c, neg_r: negr_a,
		away: oa_c | oa_r | (qa_c >= HALF_PI_Q) | (qa_r >= HALF_PI_Q)};

	logic       v_cs  [1:CSTEPS];
	cord_t      cc_cs [1:CSTEPS];
	cord_t      cr_cs [1:CSTEPS];
	cord_side_t sd_cs [1:CSTEPS];

	for (genvar i = 0; i < CSTEPS; i++) begin : g_cord
		cord_t      ci_c;
		cord_t      ci_r;
		cord_side_t si;
		logic       vi;
		if (i == 0) begin : g_first
			assign ci_c = c0_c;
			assign ci_r = c0_r;
			assign si = sd0;
			assign vi = v0;
		end else begin : g_next
			assign ci_c = cc_cs[i];
			assign ci_r = cr_cs[i];
			assign si = sd_cs[i];
			assign vi = v_cs[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_cs[i+1] <= 1'b0;
			end else begin
				v_cs[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			cc_cs[i+1] <= cord_step(ci_c, i);
			cr_cs[i+1] <= cord_step(ci_r, i);
			sd_cs[i+1] <= si;
		end
	end

	// products for the offset divisions
	cord_t              ce_c;
	cord_t              ce_r;
	cord_side_t         se;
	logic signed [33:0] yabs_c;
	logic signed [33:0] yabs_r;

	assign ce_c = cc_cs[CSTEPS];
	assign ce_r = cr_cs[CSTEPS];
	assign se = sd_cs[CSTEPS];
	assign yabs_c = (ce_c.y < 0) ? -ce_c.y : ce_c.y;
	assign yabs_r = (ce_r.y < 0) ? -ce_r.y : ce_r.y;

	logic        v_m;
	logic [55:0] pc_m;
	logic [55:0] pr_m;
	logic [63:0] dd_m;
	logic [31:0] xc_m;
	off_tag_t    otag_m;
	logic        sr_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else begin
			v_m <= v_cs[CSTEPS];
		end
	end

	always_ff @(posedge clk) begin
		pc_m <= 56'(focal_q) * 56'(yabs_c[31:0]);
		pr_m <= 56'(focal_q) * 56'(yabs_r[31:0]);
		dd_m <= 64'(ce_r.x[31:0]) * 64'(ce_c.x[31:0]);
		xc_m <= ce_c.x[31:0];
		otag_m <= '{cmd: se.cmd, row: se.row, col: se.col, rgb: se.rgb,
			away: se.away | (ce_c.x <= 0) | (ce_r.x <= 0),
			sc: se.neg_c ? (ce_c.y > 0) : (ce_c.y < 0)};
		sr_m <= se.neg_r ? (ce_r.y > 0) : (ce_r.y < 0);
	end

	// column offset = F*|st|*2^8 / ct, row offset = F*|sp|*2^38 / (cp*ct)
	logic          vo_c;
	logic          vo_r;
	logic [QW-1:0] qo_c;
	logic [QW-1:0] qo_r;
	logic          oo_c;
	logic          oo_r;
	off_tag_t      otag_o;
	logic          sr_o;

	r2e_div #(.NW(64), .DW(32), .QW(QW), .TW($bits(off_tag_t))) u_off_c (
		.clk(clk), .arst_n(arst_n), .in_valid(v_m), .num({pc_m, 8'd0}), .den(xc_m),
		.tag(otag_m), .out_valid(vo_c), .quo(qo_c), .ovf(oo_c), .out_tag(otag_o)
	);

	r2e_div #(.NW(94), .DW(64), .QW(QW), .TW(1)) u_off_r (
		.clk(clk), .arst_n(arst_n), .in_valid(v_m), .num({pr_m, 38'd0}), .den(dd_m),
		.tag(sr_m), .out_valid(vo_r), .quo(qo_r), .ovf(oo_r), .out_tag(sr_o)
	);

	// source position and range check
	logic signed [27:0] offs_c;
	logic signed [27:0] offs_r;
	logic signed [27:0] cq;
	logic signed [27:0] rq;
	logic [11:0]        c0p1;
	logic [11:0]        r0p1;
	logic               out_n;

	assign offs_c = $signed({3'b000, qo_c});
	assign offs_r = $signed({3'b000, qo_r});
	assign cq = (otag_o.sc ? -offs_c : offs_c) + $signed({4'b0000, w_eff, 15'd0});
	assign rq = (sr_o ? -offs_r : offs_r) + $signed({4'b0000, h_eff, 15'd0});
	assign c0p1 = 12'(cq[26:16]) + 12'd1;
	assign r0p1 = 12'(rq[26:16]) + 12'd1;
	assign out_n = otag_o.away | oo_c | oo_r | cq[27] | rq[27] |
		(c0p1 >= {3'b000, w_eff}) | (r0p1 >= {3'b000, h_eff});

	logic        v_p;
	logic        cmd_p;
	logic [7:0]  row_p;
	logic [7:0]  col_p;
	logic [23:0] rgb_p;
	logic        out_p;
	logic [8:0]  c0_p;
	logic [8:0]  r0_p;
	logic [15:0] dc_p;
	logic [15:0] dr_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else begin
			v_p <= vo_c & vo_r;
		end
	end

	always_ff @(posedge clk) begin
		cmd_p <= otag_o.cmd;
		row_p <= otag_o.row;
		col_p <= otag_o.col;
		rgb_p <= otag_o.rgb;
		out_p <= out_n;
		c0_p <= cq[24:16];
		r0_p <= rq[24:16];
		dc_p <= cq[15:0];
		dr_p <= rq[15:0];
	end

	// frame store: four banks by row and column parity
	logic        ld_ok;
	logic [23:0] rd_r [4];

	assign ld_ok = v_p & (cmd_p == CMD_LOAD) & (int'(row_p) < MAX_HEIGHT) &
		(int'(col_p) < MAX_WIDTH);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic RS = 1'(b / 2);
		localparam logic CS = 1'(b % 2);
		logic [23:0]   mem [BDEPTH];
		logic [9:0]    rh;
		logic [9:0]    ch;
		logic [AW-1:0] raddr;
		logic [AW-1:0] waddr;
		logic          we;

		assign rh = (10'(r0_p) + 10'(r0_p[0] ^ RS)) >> 1;
		assign ch = (10'(c0_p) + 10'(c0_p[0] ^ CS)) >> 1;
		assign raddr = {rh[RHA-1:0], ch[CHA-1:0]};
		assign waddr = {row_p[RHA:1], col_p[CHA:1]};
		assign we = ld_ok & (row_p[0] == RS) & (col_p[0] == CS);

		always_ff @(posedge clk) begin
			if (we) begin
				mem[waddr] <= rgb_p;
			end
			rd_r[b] <= mem[raddr];
		end
	end

	logic        ren_r;
	logic        hit_r;
	logic        pr_r;
	logic        pc_r;
	logic [15:0] dc_r;
	logic [15:0] dr_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ren_r <= 1'b0;
		end else begin
			ren_r <= v_p & (cmd_p == CMD_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		hit_r <= ~out_p;
		pr_r <= r0_p[0];
		pc_r <= c0_p[0];
		dc_r <= dc_p;
		dr_r <= dr_p;
	end

	// horizontal blend
	logic [1:0]  i00;
	logic [1:0]  i10;
	logic [1:0]  i01;
	logic [1:0]  i11;
	logic [16:0] wc0;
	logic [24:0] ah_n [3];
	logic [24:0] bh_n [3];

	assign i00 = {pr_r, pc_r};
	assign i10 = {pr_r, ~pc_r};
	assign i01 = {~pr_r, pc_r};
	assign i11 = {~pr_r, ~pc_r};
	assign wc0 = 17'h10000 - {1'b0, dc_r};

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			ah_n[ch] = 25'(wc0) * 25'(rd_r[i00][(2-ch)*8 +: 8]) +
				25'(dc_r) * 25'(rd_r[i10][(2-ch)*8 +: 8]);
			bh_n[ch] = 25'(wc0) * 25'(rd_r[i01][(2-ch)*8 +: 8]) +
				25'(dc_r) * 25'(rd_r[i11][(2-ch)*8 +: 8]);
		end
	end

	logic        ren_a;
	logic        hit_a;
	logic [15:0] dr_a;
	logic [24:0] ah_a [3];
	logic [24:0] bh_a [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ren_a <= 1'b0;
		end else begin
			ren_a <= ren_r;
		end
	end

	always_ff @(posedge clk) begin
		hit_a <= hit_r;
		dr_a <= dr_r;
		ah_a <= ah_n;
		bh_a <= bh_n;
	end

	// vertical blend
	logic [16:0] wr0;
	logic        ren_b;
	logic        hit_b;
	logic [40:0] sum_b [3];

	assign wr0 = 17'h10000 - {1'b0, dr_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ren_b <= 1'b0;
		end else begin
			ren_b <= ren_a;
		end
	end

	always_ff @(posedge clk) begin
		hit_b <= hit_a;
		for (int ch = 0; ch < 3; ch++) begin
			sum_b[ch] <= 41'(wr0) * 41'(ah_a[ch]) + 41'(dr_a) * 41'(bh_a[ch]);
		end
	end

	// round, clamp and present
	logic [40:0] rnd  [3];
	logic [7:0]  pix  [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			rnd[ch] = sum_b[ch] + 41'h0_8000_0000;
			pix[ch] = (rnd[ch][40:32] > 9'd255) ? 8'd255 : rnd[ch][39:32];
		end
	end

	logic       done_q;
	logic       in_view_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			in_view_q <= 1'b0;
			red_q <= 8'd0;
			green_q <= 8'd0;
			blue_q <= 8'd0;
		end else begin
			done_q <= ren_b;
			in_view_q <= ren_b & hit_b;
			red_q <= hit_b ? pix[0] : 8'd0;
			green_q <= hit_b ? pix[1] : 8'd0;
			blue_q <= hit_b ? pix[2] : 8'd0;
		end
	end

	assign done = done_q;
	assign in_view = in_view_q;
	assign out_red = red_q;
	assign out_green = green_q;
	assign out_blue = blue_q;

endmodule

### sv/r2e_checker.sv
// port checker for the remap block and its bind
`include "rectilinear_to_equirect_remap_top_assert.svh"

module r2e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       cmd,
	input logic       done,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic       in_view
);
	import r2e_pkg::*;

	`R2E_ASSERT_IMP(a_black_out_of_view, done && !in_view, out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
	`R2E_ASSERT_IMP(a_done_from_render, done, $past(start && !busy && cmd == CMD_RENDER, LATENCY))
	`R2E_ASSERT_IMP(a_load_no_result, $past(start && !busy && cmd == CMD_LOAD, LATENCY), !done)
	`R2E_ASSERT_ALW(a_quiet_in_reset, !arst_n |=> !done && !in_view)

endmodule

bind rectilinear_to_equirect_remap_top r2e_checker u_r2e_checker (.*);

### tb/sv/rectilinear_to_equirect_remap_top_test.sv
// self-checking testbench for the rectilinear to equirectangular remap block
module rectilinear_to_equirect_remap_top_test;
	import r2e_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        cmd;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [23:0] rgb;
	} pixel_cmd_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       in_view;
	} remap_px_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cmd = CMD_LOAD;
	logic [7:0]  row = '0;
	logic [7:0]  col = '0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_HEIGHT;
	logic [23:0] cfg_data = '0;
	logic        done;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        in_view;

	pixel_cmd_t pending_q[$];
	remap_px_t  remap_q[$];
	int         mismatches = 0;
	int         gap_left = 0;
	bit         gaps_on = 1'b1;

	logic [23:0] frame_m [0:65535];
	bit          written_m [0:65535];
	logic [8:0]  height_m = 9'd256;
	logic [8:0]  width_m = 9'd256;
	logic [23:0] focal_m = 24'd65536;
	logic [15:0] zoom_m = 16'd256;

	rectilinear_to_equirect_remap_top dut (.*);

	always #1 clk = ~clk;

	function automatic bit ray_trig(int twice, longint unsigned fout,
			output longint sn, output longint cs);
		longint unsigned mag;
		longint unsigned a;
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		mag = 64'(twice < 0 ? -twice : twice);
		a = (mag << 39) / fout;
		sn = 0;
		cs = 0;
		if (a >= HALF_PI_Q) return 1'b0;
		x = CORDIC_GAIN;
		y = 0;
		z = longint'(a);
		for (int i = 0; i < CSTEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= longint'(ATAN_Q24[i]);
			end else begin
				x += ys;
				y -= xs;
				z += longint'(ATAN_Q24[i]);
			end
		end
		if (x <= 0) return 1'b0;
		cs = x;
		sn = twice < 0 ? -y : y;
		return 1'b1;
	endfunction

	function automatic longint unsigned sat_quot(longint unsigned a, int sh,
			longint unsigned d);
		logic [127:0] n;
		logic [127:0] q;
		n = {64'd0, a} << sh;
		q = n / {64'd0, d};
		return q > (128'd1 << 62) ? 64'd1 << 62 : q[63:0];
	endfunction

	// traces one output pixel; r0/c0 valid when in view
	function automatic remap_px_t trace_pixel(logic [7:0] pr, logic [7:0] pc,
			output int r0, output int c0);
		remap_px_t res;
		int h;
		int w;
		longint unsigned fin;
		longint unsigned fout;
		longint unsigned off;
		longint unsigned dc;
		longint unsigned dr;
		longint unsigned s;
		longint unsigned p00;
		longint unsigned p10;
		longint unsigned p01;
		longint unsigned p11;
		longint st;
		longint ct;
		longint sp;
		longint cp;
		longint cq;
		longint rq;
		res = '{8'd0, 8'd0, 8'd0, 1'b0};
		r0 = 0;
		c0 = 0;
		h = height_m > 256 ? 256 : int'(height_m);
		w = width_m > 256 ? 256 : int'(width_m);
		fin = focal_m;
		fout = fin * zoom_m;
		if (fout == 0) return res;
		if (!ray_trig(2 * int'(pc) - w, fout, st, ct)) return res;
		if (!ray_trig(2 * int'(pr) - h, fout, sp, cp)) return res;
		off = sat_quot(fin * (st < 0 ? -st : st), 8, ct);
		cq = (st < 0 ? -longint'(off) : longint'(off)) + (longint'(w) << 15);
		if (cq < 0) return res;
		c0 = int'(cq >>> 16);
		if (c0 + 1 >= w) return res;
		off = sat_quot(fin * (sp < 0 ? -sp : sp), 38, cp * ct);
		rq = (sp < 0 ? -longint'(off) : longint'(off)) + (longint'(h) << 15);
		if (rq < 0) return res;
		r0 = int'(rq >>> 16);
		if (r0 + 1 >= h) return res;
		dc = cq & 64'hFFFF;
		dr = rq & 64'hFFFF;
		for (int ch = 0; ch < 3; ch++) begin
			p00 = (frame_m[r0 * 256 + c0] >> (16 - 8 * ch)) & 8'hFF;
			p10 = (frame_m[r0 * 256 + c0 + 1] >> (16 - 8 * ch)) & 8'hFF;
			p01 = (frame_m[(r0 + 1) * 256 + c0] >> (16 - 8 * ch)) & 8'hFF;
			p11 = (frame_m[(r0 + 1) * 256 + c0 + 1] >> (16 - 8 * ch)) & 8'hFF;
			s = (65536 - dr) * ((65536 - dc) * p00 + dc * p10) +
				dr * ((65536 - dc) * p01 + dc * p11);
			s = (s + (64'd1 << 31)) >> 32;
			if (s > 255) s = 255;
			if (ch == 0) res.r = 8'(s);
			else if (ch == 1) res.g = 8'(s);
			else res.b = 8'(s);
		end
		res.in_view = 1'b1;
		return res;
	endfunction

	task automatic push_load(logic [7:0] pr, logic [7:0] pc, logic [23:0] rgb);
		pending_q.push_back('{CMD_LOAD, pr, pc, rgb});
		frame_m[pr * 256 + pc] = rgb;
		written_m[pr * 256 + pc] = 1'b1;
	endtask

	// any unwritten neighbor gets loaded first so the store is never read blind
	task automatic push_render(logic [7:0] pr, logic [7:0] pc);
		remap_px_t res;
		int r0;
		int c0;
		res = trace_pixel(pr, pc, r0, c0);
		if (res.in_view) begin
			for (int dy = 0; dy < 2; dy++)
				for (int dx = 0; dx < 2; dx++)
					if (!written_m[(r0 + dy) * 256 + c0 + dx])
						push_load(8'(r0 + dy), 8'(c0 + dx), 24'($urandom));
			res = trace_pixel(pr, pc, r0, c0);
		end
		pending_q.push_back('{CMD_RENDER, pr, pc, 24'($urandom)});
		remap_q.push_back(res);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || remap_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(logic [8:0] h, logic [8:0] w, logic [23:0] f,
			logic [15:0] z);
		drain();
		write_reg(REG_HEIGHT, 24'(h));
		write_reg(REG_WIDTH, 24'(w));
		write_reg(REG_FOCAL, f);
		write_reg(REG_ZOOM, 24'(z));
		height_m = h;
		width_m = w;
		focal_m = f;
		zoom_m = z;
	endtask

	task automatic random_items(int n);
		int hm;
		int wm;
		logic [7:0] pr;
		logic [7:0] pc;
		hm = height_m > 256 ? 256 : (height_m < 2 ? 2 : int'(height_m));
		wm = width_m > 256 ? 256 : (width_m < 2 ? 2 : int'(width_m));
		repeat (n) begin
			pr = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) :
				$urandom_range(0, hm - 1));
			pc = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) :
				$urandom_range(0, wm - 1));
			if ($urandom_range(0, 9) < 4) push_load(pr, pc, 24'($urandom));
			else push_render(pr, pc);
		end
	endtask

	always @(posedge clk) begin
		if (start && !busy) pending_q.pop_front();
		if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_q.size() > (start && !busy ? 0 : 0) && arst_n) begin
			if (gaps_on && $urandom_range(0, 11) == 0) begin
				gap_left <= $urandom_range(0, 14);
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				cmd <= pending_q[0].cmd;
				row <= pending_q[0].row;
				col <= pending_q[0].col;
				{red, green, blue} <= pending_q[0].rgb;
			end
		end else begin
			start <= 1'b0;
		end
	end

	task automatic check_field(string name, logic [7:0] e, logic [7:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %0d got %0d", $realtime, name, e, a);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		remap_px_t e;
		if (arst_n && done) begin
			if (remap_q.size() == 0) begin
				$display("%0t: result with none expected, got %0d %0d %0d %0d", $realtime,
					out_red, out_green, out_blue, in_view);
				mismatches++;
			end else begin
				e = remap_q.pop_front();
				check_field("out_red", e.r, out_red);
				check_field("out_green", e.g, out_green);
				check_field("out_blue", e.b, out_blue);
				check_field("in_view", 8'(e.in_view), 8'(in_view));
			end
		end
	end

	initial begin
		#4000000;
		$display("rectilinear_to_equirect_remap_top regression: fail");
		$finish;
	end

	initial begin
		for (int i = 0; i < 65536; i++) begin
			frame_m[i] = '0;
			written_m[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corner loads, extreme colors, corner and center renders
		push_load(8'd0, 8'd0, 24'h000000);
		push_load(8'd255, 8'd255, 24'hFFFFFF);
		push_load(8'd0, 8'd255, 24'hFF00FF);
		push_load(8'd255, 8'd0, 24'h00FF00);
		push_render(8'd128, 8'd128);
		push_render(8'd0, 8'd0);
		push_render(8'd255, 8'd255);
		push_render(8'd127, 8'd200);
		push_render(8'd10, 8'd128);
		set_geometry(9'd256, 9'd256, 24'd256, 16'd1);
		push_render(8'd0, 8'd255);
		push_render(8'd128, 8'd129);
		set_geometry(9'd2, 9'd2, 24'hFFFFFF, 16'hFFFF);
		push_render(8'd0, 8'd0);
		push_render(8'd1, 8'd1);
		push_render(8'd255, 8'd255);
		set_geometry(9'd511, 9'd300, 24'd65536, 16'd256);
		push_render(8'd128, 8'd128);
		push_render(8'd255, 8'd0);
		set_geometry(9'd1, 9'd0, 24'd65536, 16'd256);
		push_render(8'd0, 8'd0);
		push_render(8'd200, 8'd1);
		set_geometry(9'd256, 9'd256, 24'd0, 16'd256);
		push_render(8'd128, 8'd128);
		set_geometry(9'd256, 9'd256, 24'd65536, 16'd0);
		push_render(8'd128, 8'd128);

		set_geometry(9'd256, 9'd256, 24'd65536, 16'd256);
		random_items(160);
		set_geometry(9'd100, 9'd180, 24'd25600, 16'd384);
		random_items(120);
		set_geometry(9'd256, 9'd256, 24'd8000, 16'd100);
		random_items(120);
		set_geometry(9'd2, 9'd2, 24'd512, 16'd256);
		random_items(60);
		set_geometry(9'd64, 9'd256, 24'hFFFFFF, 16'hFFFF);
		random_items(60);
		set_geometry(9'($urandom_range(2, 256)), 9'($urandom_range(2, 256)),
			24'($urandom_range(2000, 200000)), 16'($urandom_range(64, 1024)));
		random_items(120);
		set_geometry(9'd511, 9'd511, 24'd40000, 16'd200);
		random_items(80);
		gaps_on = 1'b0;
		random_items(80);

		drain();
		if (mismatches == 0)
			$display("rectilinear_to_equirect_remap_top regression: pass");
		else
			$display("rectilinear_to_equirect_remap_top regression: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/r2e_pkg.sv
sv/r2e_div.sv
sv/rectilinear_to_equirect_remap_top.sv
sv/r2e_checker.sv
tb/sv/rectilinear_to_equirect_remap_top_test.sv
